@@ sv/tlvd_pkg.sv @@
package tlvd_pkg;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_PAD     = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    ROLE_HEADER  = 2'd0,
    ROLE_PAYLOAD = 2'd1,
    ROLE_PAD     = 2'd2
  } role_e;

  typedef enum logic [1:0] {
    ST_RUN = 2'd0,
    ST_OK  = 2'd1,
    ST_BAD = 2'd2
  } status_e;

  // Header byte positions
  localparam logic [2:0] HDR_TYPE_LO = 3'd0;
  localparam logic [2:0] HDR_TYPE_HI = 3'd1;
  localparam logic [2:0] HDR_LEN_LO  = 3'd2;
  localparam logic [2:0] HDR_LEN_HI  = 3'd3;
  localparam logic [2:0] HDR_LAST    = 3'd7;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       buffer_end;
  } item_t;

  typedef struct packed {
    role_e       byte_role;
    logic [15:0] record_type;
    logic [7:0]  payload_byte;
    logic        record_end;
    logic [15:0] records_seen;
    status_e     status;
  } result_t;

  // Pad bytes needed after a payload of len bytes to reach an 8-byte boundary
  function automatic logic [2:0] pad_after(input logic [15:0] len);
    return 3'd0 - len[2:0];
  endfunction

endpackage

@@ sv/tlvd_in_if.sv @@
interface tlvd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       buffer_end;

  modport source (output valid, output in_byte, output buffer_end, input ready);
  modport sink   (input valid, input in_byte, input buffer_end, output ready);
endinterface

@@ sv/tlvd_out_if.sv @@
interface tlvd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  byte_role;
  logic [15:0] record_type;
  logic [7:0]  payload_byte;
  logic        record_end;
  logic [15:0] records_seen;
  logic [1:0]  status;

  modport source (output valid, output byte_role, output record_type, output payload_byte,
                  output record_end, output records_seen, output status, input ready);
  modport sink   (input valid, input byte_role, input record_type, input payload_byte,
                  input record_end, input records_seen, input status, output ready);
endinterface

@@ sv/tlvd_parse.sv @@
module tlvd_parse
  import tlvd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  item_t   item_i,
  output result_t res_o
);

  phase_e      phase_q, phase_d;
  logic [2:0]  hdr_idx_q, hdr_idx_d;
  logic [15:0] held_type_q, held_type_d;
  logic [15:0] held_len_q, held_len_d;
  logic [15:0] pay_left_q, pay_left_d;
  logic [2:0]  pad_left_q, pad_left_d;
  logic [15:0] count_q, count_d;
  logic        finish;

  always_comb begin
    phase_d     = phase_q;
    hdr_idx_d   = hdr_idx_q;
    held_type_d = held_type_q;
    held_len_d  = held_len_q;
    pay_left_d  = pay_left_q;
    pad_left_d  = pad_left_q;
    count_d     = count_q;
    finish      = 1'b0;

    res_o.byte_role    = ROLE_HEADER;
    res_o.record_type  = '0;
    res_o.payload_byte = '0;
    res_o.record_end   = 1'b0;
    res_o.status       = ST_RUN;

    case (phase_q)
      PH_PAYLOAD: begin
        res_o.byte_role    = ROLE_PAYLOAD;
        res_o.payload_byte = item_i.in_byte;
        res_o.record_type  = held_type_q;
        pay_left_d         = pay_left_q - 16'd1;
        if (pay_left_d == '0) begin
          finish = 1'b1;
        end
      end
      PH_PAD: begin
        res_o.byte_role = ROLE_PAD;
        pad_left_d      = pad_left_q - 3'd1;
        if (pad_left_d == '0) begin
          phase_d = PH_HEADER;
        end
      end
      default: begin
        case (hdr_idx_q)
          HDR_TYPE_LO: held_type_d = {8'd0, item_i.in_byte};
          HDR_TYPE_HI: held_type_d = {item_i.in_byte, held_type_q[7:0]};
          HDR_LEN_LO:  held_len_d  = {8'd0, item_i.in_byte};
          HDR_LEN_HI:  held_len_d  = {item_i.in_byte, held_len_q[7:0]};
          default: ;
        endcase
        if (hdr_idx_q == HDR_LAST) begin
          hdr_idx_d  = '0;
          pay_left_d = held_len_q;
          if (held_len_q == '0) begin
            res_o.record_type = held_type_q;
            finish            = 1'b1;
          end else begin
            phase_d = PH_PAYLOAD;
          end
        end else begin
          hdr_idx_d = hdr_idx_q + 3'd1;
          phase_d   = PH_HEADER;
        end
      end
    endcase

    // Close the record: bump the count and go pad or straight to the next header
    if (finish) begin
      res_o.record_end = 1'b1;
      if (count_q != COUNT_MAX) begin
        count_d = count_q + 16'd1;
      end
      pad_left_d = pad_after(held_len_q);
      phase_d    = (pad_left_d != '0) ? PH_PAD : PH_HEADER;
    end

    res_o.records_seen = count_d;

    // End of buffer: report status and drop all state for the next buffer
    if (item_i.buffer_end) begin
      res_o.status = finish ? ST_OK : ST_BAD;
      phase_d      = PH_HEADER;
      hdr_idx_d    = '0;
      held_type_d  = '0;
      held_len_d   = '0;
      pay_left_d   = '0;
      pad_left_d   = '0;
      count_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_idx_q   <= '0;
      held_type_q <= '0;
      held_len_q  <= '0;
      pay_left_q  <= '0;
      pad_left_q  <= '0;
      count_q     <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      hdr_idx_q   <= hdr_idx_d;
      held_type_q <= held_type_d;
      held_len_q  <= held_len_d;
      pay_left_q  <= pay_left_d;
      pad_left_q  <= pad_left_d;
      count_q     <= count_d;
    end
  end

endmodule

@@ sv/tlv_context_list_deframer.sv @@
// TLV context list deframer.
// in_i carries one buffer byte per beat (in_byte) with buffer_end set on the
// final byte. out_o gives exactly one result beat per input beat, in order:
// the byte's role (header, payload, pad), the record type, the payload byte,
// a record_end flag, the saturating count of records done in this buffer and,
// on the final byte only, the status (parsed fine or invalid).
// A beat accepted on in_i sits in the input register, the parse logic works on it
// there, and the result register captures the outcome once its slot is free.
// Throughput: one byte per cycle while the receiver keeps taking results, set
// by the single parse step; the parser state advances once per byte with no
// iteration.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to the start of a header with a zero record count; the end of each
// buffer does the same to the parser state.
// When the receiver stalls, the result register holds its beat, the input
// register fills with the next byte, and in_i.ready then drops until the
// result is taken. Nothing is lost or repeated.
module tlv_context_list_deframer
  import tlvd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  tlvd_in_if.sink     in_i,
  tlvd_out_if.source  out_o
);

  logic    in_vld_q;
  item_t   in_q;
  logic    out_vld_q;
  result_t out_q;
  result_t res;
  logic    advance;

  // Move the held byte into the result register when that slot frees up
  assign advance    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_i.ready) begin
      in_vld_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q.in_byte    <= in_i.in_byte;
      in_q.buffer_end <= in_i.buffer_end;
    end
  end

  tlvd_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .item_i (in_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.byte_role    = out_q.byte_role;
  assign out_o.record_type  = out_q.record_type;
  assign out_o.payload_byte = out_q.payload_byte;
  assign out_o.record_end   = out_q.record_end;
  assign out_o.records_seen = out_q.records_seen;
  assign out_o.status       = out_q.status;

  // A clean end of buffer always lands on a record's closing byte
  a_ok_on_record_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status == ST_OK) |-> out_q.record_end)
    else $error("status ok without record end");

  // A pad byte never closes a record
  a_pad_no_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.byte_role == ROLE_PAD) |-> !out_q.record_end)
    else $error("record end on pad byte");

  // Both registers full and the receiver stalled: no new byte is taken
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && out_vld_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while pipeline blocked");

  // A byte moved into the result register is presented on the next cycle
  a_advance_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced beat not presented");

endmodule
